// ===== design/lad_pkg.sv =====
// shared types and constants of the linear array deque
package lad_pkg;

  localparam int unsigned CAP_W = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_REAR  = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_REAR   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_OVER  = 2'd1,
    STATUS_UNDER = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_RESP = 3'b100
  } state_e;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic exec;
  } cmd_t;

  // handshake status seen by the controller
  typedef struct packed {
    logic in_valid;
    logic out_ready;
  } hs_t;

endpackage

// ===== design/lad_if.sv =====
// item channel interfaces of the linear array deque
interface lad_req_if #(
  parameter int unsigned DATA_WIDTH = 32
);
  logic                         valid;
  logic                         ready;
  logic [1:0]                   operation;
  logic signed [DATA_WIDTH-1:0] push_value;

  modport source (output valid, output operation, output push_value, input ready);
  modport sink (input valid, input operation, input push_value, output ready);
endinterface

interface lad_rsp_if #(
  parameter int unsigned DATA_WIDTH = 32
);
  logic                         valid;
  logic                         ready;
  logic [1:0]                   status;
  logic signed [DATA_WIDTH-1:0] popped_value;

  modport source (output valid, output status, output popped_value, input ready);
  modport sink (input valid, input status, input popped_value, output ready);
endinterface

interface lad_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [lad_pkg::CAP_W-1:0]      capacity;

  modport source (output valid, output capacity, input ready);
  modport sink (input valid, input capacity, output ready);
endinterface

// ===== design/lad_ctrl.sv =====
// request sequencer of the linear array deque
module lad_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  lad_pkg::hs_t  hs_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  output lad_pkg::cmd_t cmd_o
);

  lad_pkg::state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lad_pkg::ST_IDLE: begin
        if (hs_i.in_valid) state_d = lad_pkg::ST_EXEC;
      end
      lad_pkg::ST_EXEC: begin
        state_d = lad_pkg::ST_RESP;
      end
      lad_pkg::ST_RESP: begin
        if (hs_i.out_ready) state_d = lad_pkg::ST_IDLE;
      end
      default: begin
        state_d = lad_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lad_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o  = (state_q == lad_pkg::ST_IDLE);
  assign out_valid_o = (state_q == lad_pkg::ST_RESP);
  assign cmd_o.load  = hs_i.in_valid && (state_q == lad_pkg::ST_IDLE);
  assign cmd_o.exec  = (state_q == lad_pkg::ST_EXEC);

endmodule

// ===== design/lad_dpath.sv =====
// slot memory, marks and result registers of the linear array deque
module lad_dpath #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  lad_pkg::cmd_t                cmd_i,
  input  logic [1:0]                   operation_i,
  input  logic signed [DATA_WIDTH-1:0] push_value_i,
  input  logic                         cfg_we_i,
  input  logic [lad_pkg::CAP_W-1:0]    cfg_capacity_i,
  output logic [1:0]                   status_o,
  output logic signed [DATA_WIDTH-1:0] popped_value_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned PW = $clog2(DEPTH + 1);
  localparam int unsigned CW = (PW > lad_pkg::CAP_W) ? PW : lad_pkg::CAP_W;

  // marks are kept biased by one: 0 stands for minus one
  logic [PW-1:0]            fp_q, fp_d, rp_q, rp_d;
  logic [lad_pkg::CAP_W-1:0] cap_q;
  logic [1:0]               op_q;
  logic [DATA_WIDTH-1:0]    val_q;
  logic [DATA_WIDTH-1:0]    mem [DEPTH];
  logic [DATA_WIDTH-1:0]    rd_q;
  logic                     pop_ok_q, pop_ok_d;
  lad_pkg::status_e         status_q, status_d;
  logic                     we, re;
  logic [PW-1:0]            addr_p;
  logic [CW-1:0]            eff_cap;
  logic [PW-1:0]            fp_inc, rp_dec;

  always_comb begin
    if (cap_q == '0) begin
      eff_cap = CW'(1);
    end else if (CW'(cap_q) > CW'(DEPTH)) begin
      eff_cap = CW'(DEPTH);
    end else begin
      eff_cap = CW'(cap_q);
    end
  end

  assign fp_inc = fp_q + PW'(1);
  assign rp_dec = rp_q - PW'(1);

  always_comb begin
    fp_d     = fp_q;
    rp_d     = rp_q;
    we       = 1'b0;
    re       = 1'b0;
    addr_p   = fp_q;
    status_d = lad_pkg::STATUS_DONE;
    pop_ok_d = 1'b0;
    unique case (lad_pkg::op_e'(op_q))
      lad_pkg::OP_PUSH_FRONT: begin
        if (fp_q == '0) begin
          status_d = lad_pkg::STATUS_OVER;
        end else begin
          we     = 1'b1;
          addr_p = fp_q - PW'(1);
          fp_d   = fp_q - PW'(1);
        end
      end
      lad_pkg::OP_PUSH_REAR: begin
        if (CW'(rp_q) >= eff_cap) begin
          status_d = lad_pkg::STATUS_OVER;
        end else begin
          we     = 1'b1;
          addr_p = rp_q;
          rp_d   = rp_q + PW'(1);
        end
      end
      lad_pkg::OP_POP_FRONT: begin
        if (fp_q == rp_q) begin
          status_d = lad_pkg::STATUS_UNDER;
        end else begin
          re       = 1'b1;
          pop_ok_d = 1'b1;
          addr_p   = fp_q;
          if (fp_inc == rp_q) begin
            fp_d = '0;
            rp_d = '0;
          end else begin
            fp_d = fp_inc;
          end
        end
      end
      lad_pkg::OP_POP_REAR: begin
        if (fp_q == rp_q) begin
          status_d = lad_pkg::STATUS_UNDER;
        end else begin
          re       = 1'b1;
          pop_ok_d = 1'b1;
          addr_p   = rp_dec;
          if (rp_dec == fp_q) begin
            fp_d = '0;
            rp_d = '0;
          end else begin
            rp_d = rp_dec;
          end
        end
      end
      default: begin
        status_d = lad_pkg::STATUS_DONE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fp_q     <= '0;
      rp_q     <= '0;
      cap_q    <= lad_pkg::CAP_RESET;
      pop_ok_q <= 1'b0;
      status_q <= lad_pkg::STATUS_DONE;
    end else begin
      if (cfg_we_i) cap_q <= cfg_capacity_i;
      if (cmd_i.exec) begin
        fp_q     <= fp_d;
        rp_q     <= rp_d;
        pop_ok_q <= pop_ok_d;
        status_q <= status_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= operation_i;
      val_q <= push_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && we) mem[addr_p[AW-1:0]] <= val_q;
    if (cmd_i.exec && re) rd_q <= mem[addr_p[AW-1:0]];
  end

  assign status_o       = status_q;
  assign popped_value_o = pop_ok_q ? rd_q : '0;

endmodule

// ===== design/linear_array_deque_unit.sv =====
// top level of the linear array deque: request channel, result channel and capacity port
//
// a double-ended queue in a fixed, non-circular array of DEPTH slots of DATA_WIDTH bits.
// each request item (push front, push rear, pop front, pop rear) gives exactly one result
// item with a status (done, overflow, underflow) and the popped value, zero unless a pop
// succeeded. front and rear marks start at minus one; push front is refused while the front
// mark is at minus one, push rear is refused once the rear mark reaches the effective
// capacity minus one (capacity register clamped to 1..DEPTH), and a pop that leaves the marks
// equal resets both to minus one. requests are handled one at a time: an item is taken in
// the idle state, uses the single slot memory port in the exec state (write for a push, read
// for a pop, marks updated in the same cycle) and then holds its result in the output
// register until taken. the capacity port is always ready and should only be written while
// no request is in flight.
// the slot memory has no reset; only slots written by earlier pushes are ever read.
module linear_array_deque_unit #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  lad_req_if.sink   req_i,
  lad_rsp_if.source rsp_o,
  lad_cfg_if.sink   cfg_i
);

  lad_pkg::cmd_t cmd;
  lad_pkg::hs_t  hs;
  logic          in_ready;
  logic          out_valid;
  logic          cfg_we;

  // handshake status for the sequencer
  assign hs.in_valid  = req_i.valid;
  assign hs.out_ready = rsp_o.ready;

  // capacity writes are taken at once
  assign cfg_i.ready = 1'b1;
  assign cfg_we      = cfg_i.valid && cfg_i.ready;

  lad_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .hs_i        (hs),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .cmd_o       (cmd)
  );

  lad_dpath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .operation_i    (req_i.operation),
    .push_value_i   (req_i.push_value),
    .cfg_we_i       (cfg_we),
    .cfg_capacity_i (cfg_i.capacity),
    .status_o       (rsp_o.status),
    .popped_value_o (rsp_o.popped_value)
  );

  // request item taken only in idle, result item shown from the output register
  assign req_i.ready = in_ready;
  assign rsp_o.valid = out_valid;

endmodule

// ===== tb/linear_array_deque_checker.sv =====
// checker for the linear array deque: predicts each result item and compares it
`timescale 1ns / 100ps

module linear_array_deque_checker #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  lad_req_if   req_i,
  lad_rsp_if   rsp_i,
  lad_cfg_if   cfg_i,
  output int   mismatch_cnt_o,
  output int   results_pending_o
);

  typedef logic signed [DATA_WIDTH-1:0] word_t;

  typedef struct packed {
    lad_pkg::status_e status;
    word_t            popped;
  } deque_result_t;

  // own copy of the deque
  word_t                     slots[DEPTH];
  int                        head_pos;
  int                        tail_pos;
  logic [lad_pkg::CAP_W-1:0] cap_reg;

  deque_result_t results_due[$];
  int            mismatch_cnt;

  // applies one request to the deque copy and gives its result
  function automatic deque_result_t serve_request(lad_pkg::op_e op, word_t value);
    deque_result_t res;
    int            cap_lim;
    res.status = lad_pkg::STATUS_DONE;
    res.popped = '0;
    cap_lim = (cap_reg == 0) ? 1 : ((cap_reg > DEPTH) ? int'(DEPTH) : int'(cap_reg));
    case (op)
      lad_pkg::OP_PUSH_FRONT: begin
        if (head_pos == -1) begin
          res.status = lad_pkg::STATUS_OVER;
        end else begin
          slots[head_pos] = value;
          head_pos--;
        end
      end
      lad_pkg::OP_PUSH_REAR: begin
        if (tail_pos >= cap_lim - 1) begin
          res.status = lad_pkg::STATUS_OVER;
        end else begin
          tail_pos++;
          slots[tail_pos] = value;
        end
      end
      lad_pkg::OP_POP_FRONT: begin
        if (head_pos == tail_pos) begin
          res.status = lad_pkg::STATUS_UNDER;
        end else begin
          head_pos++;
          res.popped = slots[head_pos];
        end
      end
      default: begin
        if (head_pos == tail_pos) begin
          res.status = lad_pkg::STATUS_UNDER;
        end else begin
          res.popped = slots[tail_pos];
          tail_pos--;
        end
      end
    endcase
    // a pop that empties the deque puts both marks back at minus one
    if (res.status == lad_pkg::STATUS_DONE && head_pos == tail_pos) begin
      head_pos = -1;
      tail_pos = -1;
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    deque_result_t due;
    if (!rst_ni) begin
      foreach (slots[i]) slots[i] = '0;
      head_pos = -1;
      tail_pos = -1;
      cap_reg = lad_pkg::CAP_RESET;
      results_due.delete();
      mismatch_cnt = 0;
      mismatch_cnt_o <= 0;
      results_pending_o <= 0;
    end else begin
      // result side first, so a result with nothing pending is never masked
      if (rsp_i.valid && rsp_i.ready) begin
        if (results_due.size() == 0) begin
          $error("unrequested result item: status %0d popped_value %0d",
                 rsp_i.status, rsp_i.popped_value);
          mismatch_cnt++;
        end else begin
          due = results_due.pop_front();
          if (rsp_i.status !== due.status) begin
            $error("status: expected %0d, actual %0d", due.status, rsp_i.status);
            mismatch_cnt++;
          end
          if (rsp_i.popped_value !== due.popped) begin
            $error("popped_value: expected %0d, actual %0d", due.popped, rsp_i.popped_value);
            mismatch_cnt++;
          end
        end
      end
      if (cfg_i.valid && cfg_i.ready) cap_reg = cfg_i.capacity;
      if (req_i.valid && req_i.ready) begin
        results_due.push_back(serve_request(lad_pkg::op_e'(req_i.operation),
                                            req_i.push_value));
      end
      mismatch_cnt_o <= mismatch_cnt;
      results_pending_o <= results_due.size();
    end
  end

endmodule

// ===== tb/linear_array_deque_unit_tb.sv =====
// testbench top of the linear array deque: stimulus, receiver stalls and verdict
`timescale 1ns / 100ps

module linear_array_deque_unit_tb;

  localparam int unsigned DEPTH  = 16;
  localparam int unsigned DATA_W = 32;

  typedef logic signed [DATA_W-1:0] word_t;

  localparam word_t WORD_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  // extra wait after the last result item is back, to cover the output register
  localparam int SETTLE_CYCLES = 6;
  // long receiver hold-off, well past the one item the block can hold
  localparam int HOLD_CYCLES   = 300;
  // hard stop for about 1700 items, with the slowest phase included
  localparam int CYCLE_LIMIT   = 400000;
  localparam int PHASE_ITEMS   = 285;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  int src_idle  = 0;   // percent of cycles the sender stays idle
  int snk_stall = 0;   // percent of cycles the receiver stalls
  int hold_req  = 0;   // bumped to ask the receiver for a long hold-off
  int hold_seen = 0;
  int hold_left = 0;
  int cycle_cnt = 0;

  int mismatch_cnt;
  int results_pending;

  lad_req_if #(.DATA_WIDTH(DATA_W)) req_if ();
  lad_rsp_if #(.DATA_WIDTH(DATA_W)) rsp_if ();
  lad_cfg_if                        cfg_if ();

  linear_array_deque_unit #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_W)
  ) i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .cfg_i  (cfg_if)
  );

  linear_array_deque_checker #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_W)
  ) i_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .req_i             (req_if),
    .rsp_i             (rsp_if),
    .cfg_i             (cfg_if),
    .mismatch_cnt_o    (mismatch_cnt),
    .results_pending_o (results_pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // hard stop in case the block hangs
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // receiver: random stalls, and a counted hold-off whenever one is asked for
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else if (hold_req != hold_seen) begin
      hold_seen    <= hold_req;
      hold_left    <= HOLD_CYCLES;
      rsp_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= ($urandom_range(0, 99) >= snk_stall);
    end
  end

  // offers one request item, with random idle cycles ahead of it, and
  // returns at the edge where it is taken; valid stays high for the next item
  task automatic send_request(lad_pkg::op_e op, word_t value);
    while ($urandom_range(0, 99) < src_idle) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid      <= 1'b1;
    req_if.operation  <= op;
    req_if.push_value <= value;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
  endtask

  // stops offering and waits until every result item is back and the block idles
  task automatic wait_drained();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (results_pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // only called with the block drained
  task automatic write_capacity(logic [lad_pkg::CAP_W-1:0] cap);
    cfg_if.valid    <= 1'b1;
    cfg_if.capacity <= cap;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // one random phase: capacity and idling set up front, then a run of requests
  // that switches between filling and draining so the marks reach deep
  task automatic run_phase(logic [lad_pkg::CAP_W-1:0] cap, int src_pct, int snk_pct,
                           int hold_at, int pause_at);
    bit           filling;
    int           pick;
    lad_pkg::op_e op;
    word_t        value;
    wait_drained();
    write_capacity(cap);
    src_idle = src_pct;
    snk_stall <= snk_pct;
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      if (n % 48 == 0) filling = $urandom_range(0, 1);
      if (n == hold_at) hold_req <= hold_req + 1;
      // sender pause: let the block run dry in the middle of traffic
      if (n == pause_at) wait_drained();
      pick = $urandom_range(0, 99);
      if (filling) begin
        op = pick < 45 ? lad_pkg::OP_PUSH_REAR : pick < 65 ? lad_pkg::OP_PUSH_FRONT :
             pick < 85 ? lad_pkg::OP_POP_FRONT : lad_pkg::OP_POP_REAR;
      end else begin
        op = pick < 15 ? lad_pkg::OP_PUSH_REAR : pick < 25 ? lad_pkg::OP_PUSH_FRONT :
             pick < 65 ? lad_pkg::OP_POP_FRONT : lad_pkg::OP_POP_REAR;
      end
      // mostly random words, some extremes
      case ($urandom_range(0, 9))
        0:       value = WORD_MAX;
        1:       value = WORD_MIN;
        2:       value = '0;
        3:       value = '1;
        default: value = word_t'($urandom);
      endcase
      send_request(op, value);
    end
  endtask

  initial begin
    req_if.valid      <= 1'b0;
    req_if.operation  <= lad_pkg::OP_PUSH_FRONT;
    req_if.push_value <= '0;
    cfg_if.valid      <= 1'b0;
    cfg_if.capacity   <= lad_pkg::CAP_RESET;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // empty deque: both pops underflow, push front overflows with the front mark at minus one
    send_request(lad_pkg::OP_POP_FRONT, WORD_MAX);
    send_request(lad_pkg::OP_POP_REAR, WORD_MIN);
    send_request(lad_pkg::OP_PUSH_FRONT, 'sd1);
    // fill from the rear with the extreme values
    send_request(lad_pkg::OP_PUSH_REAR, WORD_MAX);
    send_request(lad_pkg::OP_PUSH_REAR, WORD_MIN);
    send_request(lad_pkg::OP_PUSH_REAR, '1);
    send_request(lad_pkg::OP_PUSH_REAR, '0);
    // free the front slot, reuse it, then push front overflows again
    send_request(lad_pkg::OP_POP_FRONT, '0);
    send_request(lad_pkg::OP_PUSH_FRONT, 32'sh5555_5555);
    send_request(lad_pkg::OP_PUSH_FRONT, 32'shAAAA_AAAA);
    // drain from both ends until the marks meet and go back to minus one
    send_request(lad_pkg::OP_POP_REAR, '1);
    send_request(lad_pkg::OP_POP_FRONT, '0);
    send_request(lad_pkg::OP_POP_FRONT, '0);
    send_request(lad_pkg::OP_POP_FRONT, '0);
    send_request(lad_pkg::OP_POP_REAR, '0);
    // capacity lowered below the fill level: rear pushes refused, contents stay poppable
    send_request(lad_pkg::OP_PUSH_REAR, 32'sh0F0F_0F0F);
    send_request(lad_pkg::OP_PUSH_REAR, 32'sh7070_7070);
    send_request(lad_pkg::OP_PUSH_REAR, 32'sh0123_4567);
    send_request(lad_pkg::OP_PUSH_REAR, 32'sh7654_3210);
    wait_drained();
    write_capacity(lad_pkg::CAP_W'(2));
    send_request(lad_pkg::OP_PUSH_REAR, 32'sh1111_1111);
    send_request(lad_pkg::OP_POP_REAR, '0);
    send_request(lad_pkg::OP_PUSH_REAR, 32'sh2222_2222);
    send_request(lad_pkg::OP_POP_REAR, '0);
    send_request(lad_pkg::OP_PUSH_REAR, 32'sh3333_3333);
    send_request(lad_pkg::OP_POP_FRONT, '0);
    send_request(lad_pkg::OP_POP_REAR, '0);

    // random phases through the capacity extremes (zero and above the depth clamp)
    // and the idling mixes; the first one has no idling and a long receiver hold-off
    run_phase(lad_pkg::CAP_W'(31), 0, 0, 120, -1);
    run_phase(lad_pkg::CAP_W'($urandom_range(2, 15)), 57, 0, -1, 150);
    run_phase(lad_pkg::CAP_W'(1), 0, 57, -1, -1);
    run_phase(lad_pkg::CAP_W'(16), 27, 27, -1, -1);
    run_phase(lad_pkg::CAP_W'(0), 57, 0, -1, -1);
    run_phase(lad_pkg::CAP_W'($urandom_range(17, 30)), 0, 57, -1, -1);

    wait_drained();
    if (mismatch_cnt == 0 && results_pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
